FILE: rtl/mmsh_pkg.sv
// Shared types and constants for the multi-mode string hash core.
package mmsh_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned MethW = 2;

  typedef logic [HashW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CmdW-1:0]  cmd_t;
  typedef logic [MethW-1:0] meth_t;

  // request commands
  localparam cmd_t CMD_BEGIN  = 2'd0;
  localparam cmd_t CMD_DATA   = 2'd1;
  localparam cmd_t CMD_FINISH = 2'd2;

  // hash methods
  localparam meth_t METH_FNV1A  = 2'd0;
  localparam meth_t METH_FNV1   = 2'd1;
  localparam meth_t METH_DJB2   = 2'd2;
  localparam meth_t METH_MURMUR = 2'd3;

  localparam word_t FNV_BASIS = 32'd2166136261;
  localparam word_t FNV_PRIME = 32'd16777619;
  localparam word_t DJB_START = 32'd5381;
  localparam word_t DJB_MULT  = 32'd33;
  localparam word_t MUR_M     = 32'h5bd1e995;

  localparam int unsigned MUR_R     = 24;
  localparam int unsigned MUR_FIN_A = 13;
  localparam int unsigned MUR_FIN_B = 15;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a request
    ST_BYTE,   // FNV / djb2 byte step
    ST_MK1,    // murmur k = w * m
    ST_MK2,    // murmur k = (k ^ k >> r) * m
    ST_MH,     // murmur h = h * m ^ k
    ST_FTAIL,  // murmur tail: (h ^ w) * m
    ST_FMIX,   // murmur final: (h ^ h >> 13) * m
    ST_SEND    // load the output register
  } state_t;

endpackage

FILE: rtl/mmsh_req_if.sv
// Request channel: command, data byte and message length.
interface mmsh_req_if;
  logic                  valid;
  logic                  ready;
  mmsh_pkg::cmd_t        command;
  mmsh_pkg::byte_t       data_byte;
  mmsh_pkg::word_t       message_length;

  modport source(output valid, output command, output data_byte,
                 output message_length, input ready);
  modport sink(input valid, input command, input data_byte,
               input message_length, output ready);
endinterface

FILE: rtl/mmsh_rsp_if.sv
// Result channel: the finished hash.
interface mmsh_rsp_if;
  logic            valid;
  logic            ready;
  mmsh_pkg::word_t hash_value;

  modport source(output valid, output hash_value, input ready);
  modport sink(input valid, input hash_value, output ready);
endinterface

FILE: rtl/mmsh_cfg_if.sv
// Configuration write channel: the hash method register.
interface mmsh_cfg_if;
  logic            valid;
  logic            ready;
  mmsh_pkg::meth_t hash_method;

  modport source(output valid, output hash_method, input ready);
  modport sink(input valid, input hash_method, output ready);
endinterface

FILE: rtl/multi_mode_string_hash_core.sv
// Multi-mode 32-bit string hash core: FNV-1a, FNV-1, djb2 and MurmurHash2.
//
// Hashes a byte string with the method held in the hash_method register
// (0 FNV-1a, 1 FNV-1, 2 djb2, 3 MurmurHash2 with seed 0). A begin request
// loads the start value (the message length for MurmurHash2), each data
// request folds one unsigned byte in, and a finish request returns the hash
// without disturbing the running state, so later bytes extend the message.
// All multiplies go through one 32x32 multiplier (low half kept) that a
// small sequencer reuses, and every product lands in a register. An
// FNV/djb2 byte takes one multiply; a MurmurHash2 byte is buffered, or
// takes three (k, k mix, h) when it completes a 4-byte word; a finish takes
// one for MurmurHash2, or two with a partial word pending, and none for
// FNV/djb2. The result sits in an output register, so the core goes
// back to taking requests while it waits; a second finish stalls only if
// the previous hash has not been taken. Unused command 3 is dropped.
module multi_mode_string_hash_core (
  input  logic        clk,
  input  logic        rst,
  mmsh_cfg_if.sink    cfg,
  mmsh_req_if.sink    req,
  mmsh_rsp_if.source  rsp
);

  mmsh_pkg::state_t state, state_next;

  mmsh_pkg::meth_t  method;
  mmsh_pkg::word_t  hash;       // running hash
  mmsh_pkg::word_t  wbuf;       // murmur word assembly
  logic [1:0]       phase;      // bytes held in wbuf
  mmsh_pkg::word_t  tmp;        // murmur k, or the finish copy of the hash
  mmsh_pkg::byte_t  byte_q;

  logic             req_fire;
  logic             send_ok;

  // shared multiplier
  mmsh_pkg::word_t  mul_a, mul_b, mul_p;
  logic [2*mmsh_pkg::HashW-1:0] mul_full;

  // murmur byte insertion
  mmsh_pkg::word_t  wbuf_ins;
  logic [4:0]       ins_sh;

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[mmsh_pkg::HashW-1:0];

  assign req.ready = (state == mmsh_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign send_ok   = !rsp.valid || rsp.ready;

  assign ins_sh   = {phase, 3'b000};
  assign wbuf_ins = wbuf | (mmsh_pkg::word_t'(req.data_byte) << ins_sh);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmsh_pkg::ST_IDLE: begin
        if (req_fire) begin
          priority if (req.command == mmsh_pkg::CMD_DATA) begin
            if (method != mmsh_pkg::METH_MURMUR) begin
              state_next = mmsh_pkg::ST_BYTE;
            end else if (phase == 2'd3) begin
              state_next = mmsh_pkg::ST_MK1;
            end
          end else if (req.command == mmsh_pkg::CMD_FINISH) begin
            if (method != mmsh_pkg::METH_MURMUR) begin
              state_next = mmsh_pkg::ST_SEND;
            end else if (phase != 2'd0) begin
              state_next = mmsh_pkg::ST_FTAIL;
            end else begin
              state_next = mmsh_pkg::ST_FMIX;
            end
          end else begin
            state_next = mmsh_pkg::ST_IDLE;
          end
        end
      end
      mmsh_pkg::ST_BYTE:  state_next = mmsh_pkg::ST_IDLE;
      mmsh_pkg::ST_MK1:   state_next = mmsh_pkg::ST_MK2;
      mmsh_pkg::ST_MK2:   state_next = mmsh_pkg::ST_MH;
      mmsh_pkg::ST_MH:    state_next = mmsh_pkg::ST_IDLE;
      mmsh_pkg::ST_FTAIL: state_next = mmsh_pkg::ST_FMIX;
      mmsh_pkg::ST_FMIX:  state_next = mmsh_pkg::ST_SEND;
      mmsh_pkg::ST_SEND: begin
        if (send_ok) begin
          state_next = mmsh_pkg::ST_IDLE;
        end
      end
      default: state_next = mmsh_pkg::ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = hash;
    mul_b = mmsh_pkg::MUR_M;
    unique case (state)
      mmsh_pkg::ST_BYTE: begin
        mul_a = (method == mmsh_pkg::METH_FNV1A) ?
                (hash ^ mmsh_pkg::word_t'(byte_q)) : hash;
        mul_b = (method == mmsh_pkg::METH_DJB2) ?
                mmsh_pkg::DJB_MULT : mmsh_pkg::FNV_PRIME;
      end
      mmsh_pkg::ST_MK1:   mul_a = wbuf;
      mmsh_pkg::ST_MK2:   mul_a = tmp ^ (tmp >> mmsh_pkg::MUR_R);
      mmsh_pkg::ST_MH:    mul_a = hash;
      mmsh_pkg::ST_FTAIL: mul_a = hash ^ wbuf;
      mmsh_pkg::ST_FMIX:  mul_a = tmp ^ (tmp >> mmsh_pkg::MUR_FIN_A);
      default: begin
        mul_a = hash;
        mul_b = mmsh_pkg::MUR_M;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mmsh_pkg::ST_IDLE;
      method    <= mmsh_pkg::METH_FNV1A;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        method <= cfg.hash_method;
      end
      if (state == mmsh_pkg::ST_SEND && send_ok) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      hash  <= '0;
      wbuf  <= '0;
      phase <= '0;
    end else begin
      unique case (state)
        mmsh_pkg::ST_IDLE: begin
          if (req_fire && req.command == mmsh_pkg::CMD_BEGIN) begin
            unique case (method)
              mmsh_pkg::METH_MURMUR: hash <= req.message_length;
              mmsh_pkg::METH_DJB2:   hash <= mmsh_pkg::DJB_START;
              default:               hash <= mmsh_pkg::FNV_BASIS;
            endcase
            wbuf  <= '0;
            phase <= '0;
          end else if (req_fire && req.command == mmsh_pkg::CMD_DATA &&
                       method == mmsh_pkg::METH_MURMUR) begin
            wbuf  <= wbuf_ins;
            phase <= phase + 2'd1;
          end
        end
        mmsh_pkg::ST_BYTE: begin
          unique case (method)
            mmsh_pkg::METH_FNV1:  hash <= mul_p ^ mmsh_pkg::word_t'(byte_q);
            mmsh_pkg::METH_DJB2:  hash <= mul_p + mmsh_pkg::word_t'(byte_q);
            default:              hash <= mul_p;
          endcase
        end
        mmsh_pkg::ST_MK1: wbuf <= '0;
        mmsh_pkg::ST_MH:  hash <= mul_p ^ tmp;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      byte_q <= req.data_byte;
    end
    unique case (state)
      mmsh_pkg::ST_IDLE: begin
        if (req_fire) begin
          tmp <= hash;
        end
      end
      mmsh_pkg::ST_MK1, mmsh_pkg::ST_MK2,
      mmsh_pkg::ST_FTAIL, mmsh_pkg::ST_FMIX: tmp <= mul_p;
      default: begin
      end
    endcase
    if (state == mmsh_pkg::ST_SEND && send_ok) begin
      // murmur finishes with h ^= h >> 15; other methods pass the copy
      rsp.hash_value <= (method == mmsh_pkg::METH_MURMUR) ?
                        (tmp ^ (tmp >> mmsh_pkg::MUR_FIN_B)) : tmp;
    end
  end

endmodule
